// ----- rtl/core/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, register codes and saturating fixed-point helpers for the
// PID controller with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DataWidth   = 32;
  localparam int FracBits    = 16;
  localparam int PoleWidth   = 16;
  localparam int AddrWidth   = 5;
  localparam int RegIdxWidth = 3;
  localparam int ApbWidth    = 32;

  localparam logic [RegIdxWidth-1:0] RegPropGain     = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegIntegralGain = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegDerivPole    = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegDerivGain    = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegOutMin       = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegOutMax       = 3'd5;

  typedef logic signed [DataWidth-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataWidth-1){1'b0}}};

  localparam logic signed [2*DataWidth-1:0] RoundBias =
      {{(2*DataWidth-FracBits){1'b0}}, {FracBits{1'b1}}};

  typedef struct packed {
    word_t                measurement;
    word_t                setpoint;
    logic                 auto_mode;
    word_t                manual_drive;
    logic                 freeze_high;
    logic                 freeze_low;
  } in_item_t;

  typedef struct packed {
    word_t                control_value;
    logic                 saturated_high;
    logic                 saturated_low;
    logic                 flags_changed;
  } out_item_t;

  typedef struct packed {
    word_t                prop_gain;
    word_t                integral_gain;
    logic [PoleWidth-1:0] deriv_pole;
    word_t                deriv_gain;
    word_t                out_min;
    word_t                out_max;
  } cfg_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [DataWidth:0] s;
    s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      sat_add = s[DataWidth] ? WordMin : WordMax;
    end else begin
      sat_add = s[DataWidth-1:0];
    end
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [DataWidth:0] s;
    s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      sat_sub = s[DataWidth] ? WordMin : WordMax;
    end else begin
      sat_sub = s[DataWidth-1:0];
    end
  endfunction

  // Exact product, truncate toward zero by FracBits, saturate to the word.
  function automatic word_t fix_mul(word_t a, word_t b);
    logic signed [2*DataWidth-1:0]          p;
    logic signed [2*DataWidth-1:0]          pr;
    logic        [DataWidth-FracBits:0]     hi;
    p  = a * b;
    pr = p[2*DataWidth-1] ? (p + RoundBias) : p;
    hi = pr[2*DataWidth-1:DataWidth+FracBits-1];
    if ((&hi) || (~|hi)) begin
      fix_mul = pr[DataWidth+FracBits-1:FracBits];
    end else begin
      fix_mul = pr[2*DataWidth-1] ? WordMin : WordMax;
    end
  endfunction

endpackage

// ----- rtl/core/pidaw_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pidaw_cfg_regs
// APB-style register file holding gains, derivative pole and output limits.
// ----------------------------------------------------------------------------
module pidaw_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidaw_pkg::AddrWidth-1:0] paddr,
  input  logic [pidaw_pkg::ApbWidth-1:0]  pwdata,
  output logic [pidaw_pkg::ApbWidth-1:0]  prdata,
  output logic                          pready,
  output pidaw_pkg::cfg_t               cfg_o
);

  pidaw_pkg::cfg_t                     cfg_q;
  logic [pidaw_pkg::RegIdxWidth-1:0]   reg_idx;
  logic                                wr_en;

  assign reg_idx = paddr[pidaw_pkg::AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= '0;
      cfg_q.integral_gain <= '0;
      cfg_q.deriv_pole    <= '0;
      cfg_q.deriv_gain    <= '0;
      cfg_q.out_min       <= pidaw_pkg::WordMin;
      cfg_q.out_max       <= pidaw_pkg::WordMax;
    end else if (wr_en) begin
      case (reg_idx)
        pidaw_pkg::RegPropGain:     cfg_q.prop_gain     <= pwdata;
        pidaw_pkg::RegIntegralGain: cfg_q.integral_gain <= pwdata;
        pidaw_pkg::RegDerivPole:    cfg_q.deriv_pole    <= pwdata[pidaw_pkg::PoleWidth-1:0];
        pidaw_pkg::RegDerivGain:    cfg_q.deriv_gain    <= pwdata;
        pidaw_pkg::RegOutMin:       cfg_q.out_min       <= pwdata;
        pidaw_pkg::RegOutMax:       cfg_q.out_max       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pidaw_pkg::RegPropGain:     prdata = cfg_q.prop_gain;
      pidaw_pkg::RegIntegralGain: prdata = cfg_q.integral_gain;
      pidaw_pkg::RegDerivPole:
        prdata = {{(pidaw_pkg::ApbWidth-pidaw_pkg::PoleWidth){1'b0}}, cfg_q.deriv_pole};
      pidaw_pkg::RegDerivGain:    prdata = cfg_q.deriv_gain;
      pidaw_pkg::RegOutMin:       prdata = cfg_q.out_min;
      pidaw_pkg::RegOutMax:       prdata = cfg_q.out_max;
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/pid_antiwindup_controller.sv -----
// ----------------------------------------------------------------------------
// pid_antiwindup_controller
// Fixed-point PID controller with clamp, freeze and conditional integration.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the input is not stalled. A transfer in
// loads the input register. A single combinational pass (error, four
// parallel Q16.16 products, saturating sums, clamp and freeze choice) then
// loads the result register once it is empty or being drained. The filtered
// derivative, integrator, previous error and previous drive are updated in
// the same cycle a sample moves into the result register, so back-to-back
// samples see each other's state with no gaps. Results are delivered in
// order. While a finished result waits, the input register still takes one
// more sample; the input stalls only when both registers hold a sample and
// the output is stalled.
// Write the registers only while no sample is in flight.
module pid_antiwindup_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pidaw_pkg::in_item_t             in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pidaw_pkg::out_item_t            out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pidaw_pkg::AddrWidth-1:0] paddr,
  input  logic [pidaw_pkg::ApbWidth-1:0]  pwdata,
  output logic [pidaw_pkg::ApbWidth-1:0]  prdata,
  output logic                            pready
);

  pidaw_pkg::cfg_t      cfg;

  logic                 in_valid_q;
  pidaw_pkg::in_item_t  in_q;
  logic                 out_valid_q;
  pidaw_pkg::out_item_t out_q;
  logic                 adv;

  pidaw_pkg::word_t     integral_acc_q, integral_acc_d;
  pidaw_pkg::word_t     deriv_acc_q, deriv_acc_d;
  pidaw_pkg::word_t     prev_error_q;
  pidaw_pkg::word_t     prev_drive_q;
  logic                 sat_high_q, sat_high_d;
  logic                 sat_low_q, sat_low_d;

  pidaw_pkg::word_t     err, up, derr, pole_w, int_inc, pid_sum, raw, drive;
  logic                 changed;

  pidaw_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance when the input register holds a sample and the result register is empty or being drained.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  always_comb begin
    pole_w  = {{(pidaw_pkg::DataWidth-pidaw_pkg::PoleWidth){1'b0}}, cfg.deriv_pole};
    err     = pidaw_pkg::sat_sub(in_q.setpoint, in_q.measurement);
    up      = pidaw_pkg::fix_mul(cfg.prop_gain, err);
    derr    = pidaw_pkg::sat_sub(err, prev_error_q);
    deriv_acc_d = pidaw_pkg::sat_add(pidaw_pkg::fix_mul(pole_w, deriv_acc_q),
                                     pidaw_pkg::fix_mul(cfg.deriv_gain, derr));
    int_inc = pidaw_pkg::fix_mul(cfg.integral_gain, err);
    pid_sum = pidaw_pkg::sat_add(pidaw_pkg::sat_add(up, integral_acc_q), deriv_acc_d);
    raw     = in_q.auto_mode ? pid_sum : in_q.manual_drive;

    drive          = raw;
    sat_high_d     = sat_high_q;
    sat_low_d      = sat_low_q;
    changed        = 1'b1;
    integral_acc_d = integral_acc_q;

    // Upper limit is tested first; with inverted limits, raw above out_max gets out_max, else out_min.
    if (raw > cfg.out_max) begin
      drive      = cfg.out_max;
      sat_high_d = 1'b1;
    end else if (raw < cfg.out_min) begin
      drive     = cfg.out_min;
      sat_low_d = 1'b1;
    end else if ((in_q.freeze_low && (raw < prev_drive_q)) ||
                 (in_q.freeze_high && (raw > prev_drive_q))) begin
      drive      = prev_drive_q;
      sat_high_d = in_q.freeze_high;
      sat_low_d  = in_q.freeze_low;
    end else begin
      if (in_q.auto_mode) begin
        integral_acc_d = pidaw_pkg::sat_add(integral_acc_q, int_inc);
      end else begin
        // Back-calculate the integrator for a bumpless return to auto.
        integral_acc_d = pidaw_pkg::sat_sub(pidaw_pkg::sat_sub(raw, up), deriv_acc_d);
      end
      changed    = sat_high_q || sat_low_q;
      sat_high_d = 1'b0;
      sat_low_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_acc_q <= '0;
      deriv_acc_q    <= '0;
      prev_error_q   <= '0;
      prev_drive_q   <= '0;
      sat_high_q     <= 1'b0;
      sat_low_q      <= 1'b0;
    end else if (adv) begin
      integral_acc_q <= integral_acc_d;
      deriv_acc_q    <= deriv_acc_d;
      prev_error_q   <= err;
      prev_drive_q   <= drive;
      sat_high_q     <= sat_high_d;
      sat_low_q      <= sat_low_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.control_value  <= drive;
      out_q.saturated_high <= sat_high_d;
      out_q.saturated_low  <= sat_low_d;
      out_q.flags_changed  <= changed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("result register not loaded after advance");

  a_flags_track_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_item_o.saturated_high == sat_high_q) &&
            (out_item_o.saturated_low == sat_low_q))
    else $error("output flags differ from saturation state");

  a_quiet_means_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.flags_changed) |->
      (!out_item_o.saturated_high && !out_item_o.saturated_low))
    else $error("flags set without flags_changed");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with free pipeline");
`endif

endmodule

// ----- verif/tb_pid_antiwindup_controller.sv -----
// ----------------------------------------------------------------------------
// tb_pid_antiwindup_controller
// Self-checking bench for the fixed-point PID controller. A queue-fed driver
// and a checking monitor exchange samples with the block under random idling
// on both sides. Settings are loaded over APB between idle phases. Each
// accepted sample is run through a bit-exact Q16.16 PID model that covers
// clamp, freeze, conditional integration and derivative filtering. Every
// result is compared field by field against the model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pid_antiwindup_controller;
  import pidaw_pkg::*;

  localparam int     CycleLimit = 400000;
  localparam int     HoldCycles = 150;
  localparam int     RunPhases  = 7;
  localparam int     RunLength  = 200;
  localparam longint TopL       = longint'(WordMax);
  localparam longint BotL       = longint'(WordMin);

  // Addresses past the register map; writes there must change nothing.
  localparam logic [RegIdxWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [RegIdxWidth-1:0] RegSpareHi = 3'd7;

  localparam int SendGaps[RunPhases] = '{0, 18, 0, 18, 3, 0, 8};
  localparam int TakeGaps[RunPhases] = '{0, 0, 18, 18, 3, 5, 0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid  = 1'b0;
  in_item_t             in_item   = '0;
  logic                 out_stall = 1'b0;
  logic                 hold_off  = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AddrWidth-1:0] paddr     = '0;
  logic [ApbWidth-1:0]  pwdata    = '0;
  logic [ApbWidth-1:0]  apb_rdata;
  logic                 apb_ready;
  logic                 in_stall;
  logic                 out_valid;
  out_item_t            out_item;

  // Model copy of the settings and the controller state.
  cfg_t  gains;
  word_t integ      = '0;
  word_t dfilt      = '0;
  word_t last_err   = '0;
  word_t last_drive = '0;
  logic  flag_hi    = 1'b0;
  logic  flag_lo    = 1'b0;

  in_item_t  pending_samples[$];
  out_item_t expected_results[$];

  int in_gap_max  = 0;
  int out_gap_max = 0;
  int send_wait   = 0;
  int take_wait   = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_writes    = 0;
  int n_settings  = 0;
  int n_blocked   = 0;
  int cycles      = 0;

  pid_antiwindup_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (apb_rdata),
    .pready      (apb_ready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---- Q16.16 arithmetic ---------------------------------------------------

  function automatic word_t clip_word(longint v);
    if (v > TopL) return WordMax;
    if (v < BotL) return WordMin;
    return word_t'(v);
  endfunction

  function automatic word_t clip_sum(word_t a, word_t b);
    return clip_word(longint'(a) + longint'(b));
  endfunction

  function automatic word_t clip_diff(word_t a, word_t b);
    return clip_word(longint'(a) - longint'(b));
  endfunction

  // Exact product; drop fraction bits from the magnitude so it truncates toward zero.
  function automatic word_t q_prod(word_t a, word_t b);
    longint p;
    longint mag;
    p   = longint'(a) * longint'(b);
    mag = (p < 0) ? -p : p;
    mag = mag >>> FracBits;
    return clip_word((p < 0) ? -mag : mag);
  endfunction

  // One controller step on the model state; returns the result it must produce.
  function automatic out_item_t pid_step(in_item_t s);
    word_t     err;
    word_t     up;
    word_t     drv;
    word_t     lo_lim;
    word_t     hi_lim;
    word_t     pole;
    logic      changed;
    out_item_t r;
    lo_lim = gains.out_min;
    hi_lim = gains.out_max;
    pole   = word_t'({{(DataWidth-PoleWidth){1'b0}}, gains.deriv_pole});
    err    = clip_diff(s.setpoint, s.measurement);
    up     = q_prod(gains.prop_gain, err);
    dfilt  = clip_sum(q_prod(pole, dfilt), q_prod(gains.deriv_gain, clip_diff(err, last_err)));
    if (s.auto_mode) begin
      drv = clip_sum(clip_sum(up, integ), dfilt);
    end else begin
      drv = s.manual_drive;
    end
    // Upper limit is tested first, which decides the inverted-limit case.
    if (drv > hi_lim) begin
      drv     = hi_lim;
      flag_hi = 1'b1;
      changed = 1'b1;
    end else if (drv < lo_lim) begin
      drv     = lo_lim;
      flag_lo = 1'b1;
      changed = 1'b1;
    end else if ((s.freeze_low && drv < last_drive) || (s.freeze_high && drv > last_drive)) begin
      drv     = last_drive;
      flag_hi = s.freeze_high;
      flag_lo = s.freeze_low;
      changed = 1'b1;
    end else begin
      // Integrate only when unconstrained; manual mode back-calculates.
      if (s.auto_mode) begin
        integ = clip_sum(integ, q_prod(gains.integral_gain, err));
      end else begin
        integ = clip_diff(clip_diff(drv, up), dfilt);
      end
      changed = flag_hi | flag_lo;
      flag_hi = 1'b0;
      flag_lo = 1'b0;
    end
    last_err         = err;
    last_drive       = drv;
    r.control_value  = drv;
    r.saturated_high = flag_hi;
    r.saturated_low  = flag_lo;
    r.flags_changed  = changed;
    return r;
  endfunction

  // ---- checking ------------------------------------------------------------

  task automatic flag_error(string what);
    n_errors++;
    $display("[%0t] ERROR result %0d: %s", $time, n_checked, what);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      flag_error("result with no sample outstanding");
      return;
    end
    want = expected_results.pop_front();
    if (got.control_value !== want.control_value)
      flag_error($sformatf("control_value %h, want %h", got.control_value, want.control_value));
    if (got.saturated_high !== want.saturated_high)
      flag_error($sformatf("saturated_high %b, want %b", got.saturated_high,
                           want.saturated_high));
    if (got.saturated_low !== want.saturated_low)
      flag_error($sformatf("saturated_low %b, want %b", got.saturated_low, want.saturated_low));
    if (got.flags_changed !== want.flags_changed)
      flag_error($sformatf("flags_changed %b, want %b", got.flags_changed, want.flags_changed));
  endtask

  // ---- sample driver -------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(pid_step(in_item));
        n_sent++;
      end
      if (in_valid && in_stall) n_blocked++;
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_item   <= pending_samples.pop_front();
          in_valid  <= 1'b1;
          send_wait = $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_item);
        n_checked++;
        take_wait = $urandom_range(0, out_gap_max);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_stall <= hold_off || (take_wait > 0);
    end
  end

  // Long output hold-off while samples keep coming, to back up the pipeline.
  initial begin
    wait (n_sent >= 100);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_pid_antiwindup_controller NOT OK");
    $finish;
  end

  // ---- stimulus helpers ----------------------------------------------------

  task automatic reg_write(logic [RegIdxWidth-1:0] idx, logic [ApbWidth-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!apb_ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPropGain:     gains.prop_gain     = data;
      RegIntegralGain: gains.integral_gain = data;
      RegDerivPole:    gains.deriv_pole    = data[PoleWidth-1:0];
      RegDerivGain:    gains.deriv_gain    = data;
      RegOutMin:       gains.out_min       = data;
      RegOutMax:       gains.out_max       = data;
      default: ;
    endcase
    n_writes++;
  endtask

  // Wait for every sample to come back, then let the pipeline go quiet.
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t sample_of(word_t meas, word_t setp, logic auto_on, word_t manual,
                                         logic fz_hi, logic fz_lo);
    in_item_t s;
    s.measurement  = meas;
    s.setpoint     = setp;
    s.auto_mode    = auto_on;
    s.manual_drive = manual;
    s.freeze_high  = fz_hi;
    s.freeze_low   = fz_lo;
    return s;
  endfunction

  function automatic word_t any_word();
    case ($urandom_range(0, 9))
      0:       return WordMax;
      1:       return WordMin;
      2, 3, 4: return word_t'($urandom);
      default: return word_t'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
    endcase
  endfunction

  function automatic word_t near_zero();
    return word_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
  endfunction

  function automatic word_t pick_gain(int span);
    case ($urandom_range(0, 15))
      0:       return WordMax;
      1:       return WordMin;
      2, 3:    return word_t'($urandom);
      default: return word_t'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  task automatic shuffle_settings();
    word_t lo;
    word_t hi;
    case ($urandom_range(0, 5))
      0: begin
        lo = WordMin;
        hi = WordMax;
      end
      1: begin
        lo = word_t'(int'($urandom_range(1, 200)) << FracBits);
        hi = -word_t'(int'($urandom_range(1, 200)) << FracBits);
      end
      default: begin
        lo = -word_t'(int'($urandom_range(1, 1000)) << FracBits);
        hi = word_t'(int'($urandom_range(1, 1000)) << FracBits);
      end
    endcase
    reg_write(RegPropGain, pick_gain(32'h0008_0000));
    reg_write(RegIntegralGain, pick_gain(32'h0000_4000));
    reg_write(RegDerivPole, $urandom);
    reg_write(RegDerivGain, pick_gain(32'h0004_0000));
    reg_write(RegOutMin, lo);
    reg_write(RegOutMax, hi);
    n_settings++;
  endtask

  // Mostly tracking runs around a target, some manual stretches, some noise.
  task automatic queue_random_run(int count);
    in_item_t s;
    word_t    target;
    int       kind;
    int       seg;
    while (count > 0) begin
      kind   = $urandom_range(0, 19);
      seg    = $urandom_range(5, 30);
      target = any_word();
      for (int k = 0; k < seg && count > 0; k++) begin
        s.setpoint     = target;
        s.manual_drive = word_t'($urandom);
        s.freeze_high  = ($urandom_range(0, 9) == 0);
        s.freeze_low   = ($urandom_range(0, 9) == 0);
        if (kind < 13) begin
          s.measurement = target + near_zero();
          s.auto_mode   = 1'b1;
        end else if (kind < 17) begin
          s.measurement  = target + near_zero();
          s.manual_drive = target + near_zero();
          s.auto_mode    = 1'b0;
        end else begin
          s.measurement = any_word();
          s.setpoint    = any_word();
          s.auto_mode   = 1'($urandom_range(0, 1));
          s.freeze_high = 1'($urandom_range(0, 1));
          s.freeze_low  = 1'($urandom_range(0, 1));
        end
        pending_samples.push_back(s);
        count--;
      end
    end
  endtask

  // ---- test sequence -------------------------------------------------------

  initial begin
    gains         = '0;
    gains.out_min = WordMin;
    gains.out_max = WordMax;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    n_settings = 1;

    // Settings after reset: zero gains, full-range limits.
    in_gap_max  = 2;
    out_gap_max = 2;
    pending_samples.push_back(sample_of('0, '0, 1'b1, '0, 1'b0, 1'b0));
    pending_samples.push_back(sample_of(WordMax, WordMin, 1'b0, WordMax, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, WordMin, 1'b0, 1'b1));
    pending_samples.push_back(sample_of('0, '0, 1'b0, WordMin, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, WordMax, 1'b1, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, '0, 1'b1, 1'b1));
    pending_samples.push_back(sample_of(WordMin, WordMax, 1'b1, '0, 1'b0, 1'b0));
    pending_samples.push_back(sample_of(WordMax, WordMin, 1'b1, WordMax, 1'b1, 1'b1));
    drain();

    // Extreme gains, narrow limits of +/-100.0.
    reg_write(RegPropGain, WordMax);
    reg_write(RegIntegralGain, WordMin);
    reg_write(RegDerivPole, 32'hA5A5_FFFF);
    reg_write(RegDerivGain, WordMax);
    reg_write(RegOutMin, -(32'sd100 <<< FracBits));
    reg_write(RegOutMax, 32'sd100 <<< FracBits);
    n_settings++;
    pending_samples.push_back(sample_of('0, 32'sd1 <<< FracBits, 1'b1, '0, 1'b0, 1'b0));
    pending_samples.push_back(sample_of(32'sd1 <<< FracBits, '0, 1'b1, '0, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b1, '0, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, 32'sd50 <<< FracBits, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, 32'sd200 <<< FracBits, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, -(32'sd200 <<< FracBits), 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, 32'sd10 <<< FracBits, 1'b0, 1'b1));
    pending_samples.push_back(sample_of('0, '0, 1'b0, 32'sd5 <<< FracBits, 1'b0, 1'b1));
    pending_samples.push_back(sample_of('0, '0, 1'b1, '0, 1'b0, 1'b0));
    drain();

    // Inverted limits and zero pole; writes past the map must be ignored.
    reg_write(RegPropGain, 32'h0001_0000);
    reg_write(RegIntegralGain, 32'h0000_1000);
    reg_write(RegDerivPole, 32'h0000_0000);
    reg_write(RegDerivGain, 32'h0000_0000);
    reg_write(RegOutMin, 32'sd50 <<< FracBits);
    reg_write(RegOutMax, -(32'sd50 <<< FracBits));
    reg_write(RegSpareLo, $urandom);
    reg_write(RegSpareHi, $urandom);
    n_settings++;
    pending_samples.push_back(sample_of('0, '0, 1'b0, '0, 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b0, -(32'sd100 <<< FracBits), 1'b0, 1'b0));
    pending_samples.push_back(sample_of('0, '0, 1'b1, '0, 1'b0, 1'b0));
    drain();

    for (int ph = 0; ph < RunPhases; ph++) begin
      shuffle_settings();
      in_gap_max  = SendGaps[ph];
      out_gap_max = TakeGaps[ph];
      queue_random_run(RunLength);
      drain();
    end
    repeat (8) @(posedge clk_i);

    $display("Ran %0d samples under %0d settings (%0d APB writes); %0d results checked.",
             n_sent, n_settings, n_writes, n_checked);
    $display("Input back-pressure seen for %0d cycles around a %0d-cycle output hold; %0d errors.",
             n_blocked, HoldCycles, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_pid_antiwindup_controller OK");
    end else begin
      $display("tb_pid_antiwindup_controller NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_cfg_regs.sv
rtl/core/pid_antiwindup_controller.sv
verif/tb_pid_antiwindup_controller.sv
